// File: sv/sduc_pkg.sv
// Shared types, codes and reset values of the SDO upload client.
// No dependencies; imported by every other file of the block.
`default_nettype none

package sduc_pkg;

    // Request kinds of one input beat
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Transfer status
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
    localparam logic [2:0] ERR_ABORT    = 3'd2;
    localparam logic [2:0] ERR_BAD_SCS  = 3'd3;
    localparam logic [2:0] ERR_BAD_ES   = 3'd4;
    localparam logic [2:0] ERR_TOGGLE   = 3'd5;

    // Server command specifiers
    localparam logic [2:0] SCS_SEGMENT     = 3'd0;
    localparam logic [2:0] SCS_INIT_UPLOAD = 3'd2;
    localparam logic [2:0] SCS_ABORT       = 3'd4;

    // Client command bytes
    localparam logic [7:0] CMD_INIT_UPLOAD = 8'h40;
    localparam logic [7:0] CMD_SEG_REQ     = 8'h60;

    // Configuration register indexes
    localparam logic [1:0] CFG_RESPONSE_ID = 2'd0;
    localparam logic [1:0] CFG_REQUEST_ID  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [10:0] RESPONSE_ID_RST = 11'd1408;
    localparam logic [10:0] REQUEST_ID_RST  = 11'd1536;
    localparam logic [15:0] TIMEOUT_RST     = 16'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] frame_id;
        logic [63:0] frame_payload;
        logic [15:0] object_index;
        logic [7:0]  object_subindex;
    } t_item;

    typedef struct packed {
        logic [10:0] response_id;
        logic [10:0] request_id;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic        busy;
        logic        segment_phase;
        logic        toggle_bit;
        logic [31:0] received_count;
        logic [31:0] indicated_size;
        logic [15:0] idle_ticks;
        logic [1:0]  status;
        logic [2:0]  error_code;
        logic [31:0] abort_code;
    } t_state;

    typedef struct packed {
        logic        tx_valid;
        logic [10:0] tx_id;
        logic [63:0] tx_payload;
        logic        chunk_valid;
        logic [55:0] chunk_bytes;
        logic [2:0]  chunk_count;
        logic [1:0]  status;
        logic [2:0]  error_code;
        logic [31:0] abort_code;
        logic [31:0] total_size;
    } t_result;

    // Mask that keeps the low cnt bytes of a 7-byte word
    function automatic logic [55:0] byte_mask(input logic [2:0] cnt);
        logic [55:0] m;
        case (cnt)
            3'd0:    m = 56'h00000000000000;
            3'd1:    m = 56'h000000000000FF;
            3'd2:    m = 56'h0000000000FFFF;
            3'd3:    m = 56'h00000000FFFFFF;
            3'd4:    m = 56'h000000FFFFFFFF;
            3'd5:    m = 56'h0000FFFFFFFFFF;
            3'd6:    m = 56'h00FFFFFFFFFFFF;
            default: m = 56'hFFFFFFFFFFFFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: sv/sduc_decode.sv
// Single-pass SDO protocol decode: next transfer state and result of one beat.
// Depends on sduc_pkg.
`default_nettype none

module sduc_decode (
    input  sduc_pkg::t_item   i_item,
    input  sduc_pkg::t_state  i_state,
    input  sduc_pkg::t_cfg    i_cfg,
    output sduc_pkg::t_state  o_state,
    output sduc_pkg::t_result o_result
);
    import sduc_pkg::*;

    logic [7:0]  b0;
    logic [2:0]  scs;
    logic [2:0]  exp_size;
    logic [2:0]  seg_size;
    logic [15:0] idle_inc;
    t_state      nxt;
    t_result     res;

    assign b0       = i_item.frame_payload[7:0];
    assign scs      = b0[7:5];
    assign exp_size = b0[0] ? (3'd4 - {1'b0, b0[3:2]}) : 3'd4;
    assign seg_size = 3'd7 - b0[3:1];
    assign idle_inc = i_state.idle_ticks + 16'd1;

    always_comb begin
        nxt = i_state;
        res = '0;
        case (i_item.req_type)
            REQ_START: begin
                nxt.busy           = 1'b1;
                nxt.segment_phase  = 1'b0;
                nxt.toggle_bit     = 1'b0;
                nxt.received_count = '0;
                nxt.indicated_size = '0;
                nxt.idle_ticks     = '0;
                nxt.status         = ST_BUSY;
                nxt.error_code     = ERR_NONE;
                nxt.abort_code     = '0;
                res.tx_valid       = 1'b1;
                res.tx_payload     = {32'd0, i_item.object_subindex,
                                      i_item.object_index, CMD_INIT_UPLOAD};
            end
            REQ_FRAME: begin
                if (i_state.busy && i_item.frame_id == i_cfg.response_id) begin
                    nxt.idle_ticks = '0;
                    if (scs == SCS_ABORT) begin
                        nxt.abort_code = i_item.frame_payload[63:32];
                        nxt.busy       = 1'b0;
                        nxt.status     = ST_FAIL;
                        nxt.error_code = ERR_ABORT;
                    end else if (!i_state.segment_phase) begin
                        if (scs != SCS_INIT_UPLOAD) begin
                            nxt.busy       = 1'b0;
                            nxt.status     = ST_FAIL;
                            nxt.error_code = ERR_BAD_SCS;
                        end else if (b0[1]) begin
                            // expedited: data in bytes 4..7
                            res.chunk_valid    = 1'b1;
                            res.chunk_count    = exp_size;
                            res.chunk_bytes    = {24'd0, i_item.frame_payload[63:32]}
                                                 & byte_mask(exp_size);
                            nxt.received_count = {29'd0, exp_size};
                            nxt.indicated_size = {29'd0, exp_size};
                            nxt.busy           = 1'b0;
                            nxt.status         = ST_DONE;
                        end else if (b0[0]) begin
                            nxt.indicated_size = i_item.frame_payload[63:32];
                            nxt.segment_phase  = 1'b1;
                            res.tx_valid       = 1'b1;
                            res.tx_payload     = {56'd0, CMD_SEG_REQ
                                                  | {3'd0, i_state.toggle_bit, 4'd0}};
                        end else begin
                            nxt.busy       = 1'b0;
                            nxt.status     = ST_FAIL;
                            nxt.error_code = ERR_BAD_ES;
                        end
                    end else begin
                        if (scs != SCS_SEGMENT) begin
                            nxt.busy       = 1'b0;
                            nxt.status     = ST_FAIL;
                            nxt.error_code = ERR_BAD_SCS;
                        end else if (b0[4] != i_state.toggle_bit) begin
                            nxt.busy       = 1'b0;
                            nxt.status     = ST_FAIL;
                            nxt.error_code = ERR_TOGGLE;
                        end else begin
                            res.chunk_valid    = 1'b1;
                            res.chunk_count    = seg_size;
                            res.chunk_bytes    = i_item.frame_payload[63:8]
                                                 & byte_mask(seg_size);
                            nxt.received_count = i_state.received_count
                                                 + {29'd0, seg_size};
                            nxt.toggle_bit     = !i_state.toggle_bit;
                            if (b0[0]) begin
                                nxt.busy   = 1'b0;
                                nxt.status = ST_DONE;
                            end else begin
                                res.tx_valid   = 1'b1;
                                res.tx_payload = {56'd0, CMD_SEG_REQ
                                                  | {3'd0, !i_state.toggle_bit, 4'd0}};
                            end
                        end
                    end
                end
            end
            REQ_TICK: begin
                if (i_state.busy) begin
                    nxt.idle_ticks = idle_inc;
                    if (idle_inc >= i_cfg.timeout_ticks) begin
                        nxt.busy       = 1'b0;
                        nxt.status     = ST_FAIL;
                        nxt.error_code = ERR_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
        res.tx_id      = res.tx_valid ? i_cfg.request_id : 11'd0;
        res.status     = nxt.status;
        res.error_code = nxt.error_code;
        res.abort_code = nxt.abort_code;
        res.total_size = (nxt.indicated_size != 32'd0) ? nxt.indicated_size
                                                       : nxt.received_count;
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule

`default_nettype wire

// File: sv/sdo_upload_client_core.sv
// Top level of the CANopen SDO upload client: input register, decode, result register.
// Depends on sduc_pkg and sduc_decode.
//
// Each beat (start, received frame or timer tick) yields exactly one result beat.
// The block takes one beat per clock while o_stall is low. An accepted beat sits in the
// input register, the whole protocol decode is done combinationally between the input
// and result registers, and the result is loaded into the result register, which drives
// the outputs, once that register is free (no result waiting under stall). While a
// result waits, the input side still accepts a beat as long as the input register is empty.
// Configuration writes are meant for idle periods only.
`default_nettype none

module sdo_upload_client_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    // input channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [10:0] i_frame_id,
    input  wire  [63:0] i_frame_payload,
    input  wire  [15:0] i_object_index,
    input  wire  [7:0]  i_object_subindex,
    // result channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_tx_valid,
    output logic [10:0] o_tx_id,
    output logic [63:0] o_tx_payload,
    output logic        o_chunk_valid,
    output logic [55:0] o_chunk_bytes,
    output logic [2:0]  o_chunk_count,
    output logic [1:0]  o_status,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_abort_code,
    output logic [31:0] o_total_size
);
    import sduc_pkg::*;

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_vld;
    t_state  r_st;
    t_state  n_st;
    t_result r_out;
    t_result n_out;
    logic    r_out_vld;
    logic    out_free;
    logic    step_go;
    logic    in_take;

    assign out_free = !r_out_vld || !i_stall;
    assign step_go  = r_in_vld && out_free;
    assign in_take  = i_valid && !o_stall;
    assign o_stall  = r_in_vld && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.response_id   <= RESPONSE_ID_RST;
            r_cfg.request_id    <= REQUEST_ID_RST;
            r_cfg.timeout_ticks <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RESPONSE_ID: r_cfg.response_id   <= i_cfg_data[10:0];
                CFG_REQUEST_ID:  r_cfg.request_id    <= i_cfg_data[10:0];
                CFG_TIMEOUT:     r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type        <= i_req_type;
            r_in.frame_id        <= i_frame_id;
            r_in.frame_payload   <= i_frame_payload;
            r_in.object_index    <= i_object_index;
            r_in.object_subindex <= i_object_subindex;
        end
        if (step_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (step_go) begin
                r_in_vld <= 1'b0;
            end
            if (step_go) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    sduc_decode u_decode (
        .i_item   (r_in),
        .i_state  (r_st),
        .i_cfg    (r_cfg),
        .o_state  (n_st),
        .o_result (n_out)
    );

    assign o_valid       = r_out_vld;
    assign o_tx_valid    = r_out.tx_valid;
    assign o_tx_id       = r_out.tx_id;
    assign o_tx_payload  = r_out.tx_payload;
    assign o_chunk_valid = r_out.chunk_valid;
    assign o_chunk_bytes = r_out.chunk_bytes;
    assign o_chunk_count = r_out.chunk_count;
    assign o_status      = r_out.status;
    assign o_error_code  = r_out.error_code;
    assign o_abort_code  = r_out.abort_code;
    assign o_total_size  = r_out.total_size;

endmodule

`default_nettype wire

// File: sv/sduc_checker.sv
// Port-level assertions for the SDO upload client, bound to the top level.
// Depends on sduc_pkg and sdo_upload_client_core.
`default_nettype none

module sduc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_tx_valid,
    input wire [10:0] o_tx_id,
    input wire [63:0] o_tx_payload,
    input wire        o_chunk_valid,
    input wire [55:0] o_chunk_bytes,
    input wire [2:0]  o_chunk_count,
    input wire [1:0]  o_status,
    input wire [2:0]  o_error_code
);
    import sduc_pkg::*;

    // stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx_payload)
                               && $stable(o_chunk_bytes) && $stable(o_status))
        else $error("result beat changed under stall");

    a_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_id == 11'd0 && o_tx_payload == 64'd0)
        else $error("tx fields set without tx_valid");

    a_no_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_chunk_valid |-> o_chunk_count == 3'd0 && o_chunk_bytes == 56'd0)
        else $error("chunk fields set without chunk_valid");

    a_err_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_FAIL) == (o_error_code != ERR_NONE))
        else $error("error code does not match failed status");

endmodule

bind sdo_upload_client_core sduc_checker u_sduc_checker (.*);

`default_nettype wire
